// ----- rtl/core/ldsa_pkg.sv -----
// ----------------------------------------------------------------------------
// ldsa_pkg
// Shared types and constants of the double-ended scratch allocator.
// ----------------------------------------------------------------------------
package ldsa_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned MARK_W  = 25;
  localparam int unsigned SIZE_W  = 26;
  localparam int unsigned REL_W   = 26;
  localparam int unsigned STEP_W  = 16;
  localparam int unsigned ADDR_W  = 24;
  localparam int unsigned ROLE_W  = 2;
  localparam int unsigned STAT_W  = 2;

  localparam logic [MARK_W-1:0] SCRATCH_BYTES_RST = 25'd1048576;

  // Request modes.
  localparam logic MODE_PLACE = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;

  // Buffer roles; any other code is handled as an intermediate.
  localparam logic [ROLE_W-1:0] ROLE_IN  = 2'd0;
  localparam logic [ROLE_W-1:0] ROLE_OUT = 2'd1;

  // Result status codes.
  localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOROOM = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL   = 2'd2;
  localparam logic [STAT_W-1:0] STAT_BAD    = 2'd3;

  // One entry of the active table.
  typedef struct packed {
    logic              valid;
    logic [STEP_W-1:0] last_use;
    logic [REL_W-1:0]  rel;
  } entry_t;

  // Controls broadcast to every cell of the chain.
  typedef struct packed {
    logic shift;
    logic clear;
    logic wr_en;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_PLACE,
    ST_PONG,
    ST_EMIT
  } state_t;

endpackage

// ----- rtl/core/ldsa_cell.sv -----
// ----------------------------------------------------------------------------
// ldsa_cell
// One entry of the active table, linked into a rotating chain of cells.
// ----------------------------------------------------------------------------
module ldsa_cell #(
  parameter int unsigned INDEX = 0,
  parameter int unsigned IDX_W = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ldsa_pkg::cell_ctl_t ctl,
  input  logic [IDX_W-1:0]    wr_slot,
  input  ldsa_pkg::entry_t    wr_data,
  input  ldsa_pkg::entry_t    shift_in,
  output ldsa_pkg::entry_t    q
);

  logic             wr_hit;
  ldsa_pkg::entry_t entry_r;

  assign wr_hit = ctl.wr_en && (wr_slot == IDX_W'(INDEX));

  // Payload moves along with the valid bit; only the valid bit is cleared by
  // reset or a clear request.
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      entry_r.last_use <= shift_in.last_use;
      entry_r.rel      <= shift_in.rel;
    end else if (wr_hit) begin
      entry_r.last_use <= wr_data.last_use;
      entry_r.rel      <= wr_data.rel;
    end
    if (!rst_n) begin
      entry_r.valid <= 1'b0;
    end else if (ctl.clear) begin
      entry_r.valid <= 1'b0;
    end else if (ctl.shift) begin
      entry_r.valid <= shift_in.valid;
    end else if (wr_hit) begin
      entry_r.valid <= wr_data.valid;
    end
  end

  assign q = entry_r;

endmodule

// ----- rtl/core/ldsa_align.sv -----
// ----------------------------------------------------------------------------
// ldsa_align
// Round-up of a request size to a multiple of the alignment.
// ----------------------------------------------------------------------------
module ldsa_align #(
  parameter int unsigned ALIGN_BYTES = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ldsa_pkg::MARK_W-1:0] bytes_i,
  output logic [ldsa_pkg::SIZE_W-1:0] size_o,
  output logic                        done_o
);

  localparam int unsigned TW = ldsa_pkg::SIZE_W;
  localparam logic [TW-1:0] BIAS_C = TW'(ALIGN_BYTES - 1);

  logic          done_r, done_nxt;
  logic [TW-1:0] size_r, size_nxt;

  // The alignment is a power of two, so rounding up is an add and a mask.
  always_comb begin
    done_nxt = done_r;
    size_nxt = size_r;
    if (start) begin
      size_nxt = (TW'(bytes_i) + BIAS_C) & ~BIAS_C;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    size_r <= size_nxt;
  end

  assign size_o = size_r;
  assign done_o = done_r;

endmodule

// ----- rtl/core/liveness_dual_end_sram_allocator_core.sv -----
// A place request passes through the walk, placement, pong try and result
// load from its acceptance to its result word, and a spill skips the pong
// try: the active table is a ring of ACTIVE_DEPTH cells that rotates once per
// place request, one entry past the retire logic per cycle, while the size is
// rounded up in a register at acceptance. A clear request goes straight to
// the result load. The next word is taken once the current result sits in
// the output register, so a new request is never taken while another is in
// work; the result waits there until the sink takes it, and the next request
// holds in its last step meanwhile. ALIGN_BYTES must be a power of two.
// Inputs and intermediates grow upward from the low mark, outputs downward
// from the high mark; the scratch size register takes effect at reset or at
// the next clear.
// ----------------------------------------------------------------------------
// liveness_dual_end_sram_allocator_core
// Double-ended scratch memory allocator with liveness-based reuse.
// ----------------------------------------------------------------------------
module liveness_dual_end_sram_allocator_core #(
  parameter int unsigned ACTIVE_DEPTH = 64,
  parameter int unsigned ALIGN_BYTES  = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration: total scratch bytes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [24:0] cfg_data,
  // Requests.
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata: bytes[24:0], first_use[40:25], last_use[56:41], in_tile_loop[57], zero pad.
  input  logic [63:0] in_tdata,
  // tuser: mode[0], role[2:1].
  input  logic [2:0]  in_tuser,
  // Results.
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata: address[23:0], pong_placed[24], pong_address[48:25], free_bytes[73:49],
  // zero pad.
  output logic [79:0] out_tdata,
  // tuser: status[1:0].
  output logic [1:0]  out_tuser
);

  localparam int unsigned IDX_W = (ACTIVE_DEPTH > 1) ? $clog2(ACTIVE_DEPTH) : 1;
  localparam int unsigned MW = ldsa_pkg::MARK_W;
  localparam int unsigned SW = ldsa_pkg::SIZE_W;

  ldsa_pkg::state_t state_r, state_nxt;

  logic [MW-1:0]               sram_r;
  logic [MW-1:0]               low_r, low_nxt;
  logic [MW-1:0]               high_r, high_nxt;
  logic [IDX_W-1:0]            cnt_r, cnt_nxt;
  logic [IDX_W-1:0]            slot_r, slot_nxt;
  logic                        found_r, found_nxt;
  logic [ldsa_pkg::ROLE_W-1:0] role_r, role_nxt;
  logic                        tile_r, tile_nxt;
  logic [ldsa_pkg::STEP_W-1:0] first_r, first_nxt;
  logic [ldsa_pkg::STEP_W-1:0] last_r, last_nxt;
  logic [ldsa_pkg::STAT_W-1:0] status_r, status_nxt;
  logic [ldsa_pkg::ADDR_W-1:0] addr_r, addr_nxt;
  logic                        pong_r, pong_nxt;
  logic [ldsa_pkg::ADDR_W-1:0] paddr_r, paddr_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [ldsa_pkg::STAT_W-1:0] o_status_r, o_status_nxt;
  logic [ldsa_pkg::ADDR_W-1:0] o_addr_r, o_addr_nxt;
  logic                        o_pong_r, o_pong_nxt;
  logic [ldsa_pkg::ADDR_W-1:0] o_paddr_r, o_paddr_nxt;
  logic [MW-1:0]               o_free_r, o_free_nxt;

  ldsa_pkg::cell_ctl_t ctl;
  ldsa_pkg::entry_t    wr_data;
  ldsa_pkg::entry_t    head_back;
  ldsa_pkg::entry_t    cell_q [ACTIVE_DEPTH];
  ldsa_pkg::entry_t    cell_d [ACTIVE_DEPTH];

  logic          align_start;
  logic [SW-1:0] size;
  logic          size_done;
  logic          kill;
  logic [SW:0]   sum;
  logic          fits;
  logic [MW:0]   diff;
  logic          in_acc;

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == ldsa_pkg::ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // Size rounding runs alongside the table walk.
  ldsa_align #(
    .ALIGN_BYTES(ALIGN_BYTES)
  ) u_align (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (align_start),
    .bytes_i(in_tdata[24:0]),
    .size_o (size),
    .done_o (size_done)
  );

  // Ring of table cells; the head entry is examined and fed back to the tail.
  for (genvar i = 0; i < ACTIVE_DEPTH; i++) begin : g_cell
    if (i == ACTIVE_DEPTH - 1) begin : g_tail
      assign cell_d[i] = head_back;
    end else begin : g_link
      assign cell_d[i] = cell_q[i+1];
    end
    ldsa_cell #(
      .INDEX(i),
      .IDX_W(IDX_W)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .wr_slot (slot_r),
      .wr_data (wr_data),
      .shift_in(cell_d[i]),
      .q       (cell_q[i])
    );
  end

  // Retirement test on the entry at the head of the ring.
  always_comb begin
    kill            = cell_q[0].valid && (cell_q[0].last_use < first_r);
    head_back       = cell_q[0];
    head_back.valid = cell_q[0].valid && !kill;
  end

  // Fit test: a zero size always fits, otherwise low + size must not pass high.
  assign sum  = (SW+1)'(low_r) + (SW+1)'(size);
  assign fits = (size == '0) || (sum <= (SW+1)'(high_r));
  assign diff = {1'b0, high_r} - {1'b0, low_r};

  // Sequencer: accept, walk, place, pong try, load result; a clear goes straight to the result load.
  always_comb begin
    state_nxt     = state_r;
    low_nxt       = low_r;
    high_nxt      = high_r;
    cnt_nxt       = cnt_r;
    slot_nxt      = slot_r;
    found_nxt     = found_r;
    role_nxt      = role_r;
    tile_nxt      = tile_r;
    first_nxt     = first_r;
    last_nxt      = last_r;
    status_nxt    = status_r;
    addr_nxt      = addr_r;
    pong_nxt      = pong_r;
    paddr_nxt     = paddr_r;
    out_valid_nxt = out_valid_r && !out_tready;
    o_status_nxt  = o_status_r;
    o_addr_nxt    = o_addr_r;
    o_pong_nxt    = o_pong_r;
    o_paddr_nxt   = o_paddr_r;
    o_free_nxt    = o_free_r;
    ctl           = '0;
    align_start   = 1'b0;
    wr_data.valid    = 1'b1;
    wr_data.last_use = last_r;
    wr_data.rel      = (role_r == ldsa_pkg::ROLE_OUT) ? '0 : size;

    unique case (state_r)
      ldsa_pkg::ST_IDLE: begin
        if (in_acc) begin
          role_nxt   = in_tuser[2:1];
          tile_nxt   = in_tdata[57];
          first_nxt  = in_tdata[40:25];
          last_nxt   = in_tdata[56:41];
          status_nxt = ldsa_pkg::STAT_OK;
          addr_nxt   = '0;
          pong_nxt   = 1'b0;
          paddr_nxt  = '0;
          cnt_nxt    = '0;
          found_nxt  = 1'b0;
          if (in_tuser[0] == ldsa_pkg::MODE_CLEAR) begin
            ctl.clear = 1'b1;
            low_nxt   = '0;
            high_nxt  = sram_r;
            state_nxt = ldsa_pkg::ST_EMIT;
          end else begin
            align_start = 1'b1;
            state_nxt   = ldsa_pkg::ST_WALK;
          end
        end
      end

      ldsa_pkg::ST_WALK: begin
        ctl.shift = 1'b1;
        if (kill) begin
          low_nxt = ({1'b0, low_r} > head_back.rel) ?
                    (low_r - head_back.rel[MW-1:0]) : '0;
        end
        if (!head_back.valid && !found_r) begin
          slot_nxt  = cnt_r;
          found_nxt = 1'b1;
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == IDX_W'(ACTIVE_DEPTH - 1)) begin
          state_nxt = ldsa_pkg::ST_PLACE;
        end
      end

      ldsa_pkg::ST_PLACE: begin
        if (size_done) begin
          if (!found_r) begin
            status_nxt = ldsa_pkg::STAT_FULL;
            state_nxt  = ldsa_pkg::ST_EMIT;
          end else if (!fits) begin
            status_nxt = ldsa_pkg::STAT_NOROOM;
            state_nxt  = ldsa_pkg::ST_EMIT;
          end else if (role_r == ldsa_pkg::ROLE_OUT) begin
            high_nxt  = high_r - size[MW-1:0];
            addr_nxt  = high_nxt[ldsa_pkg::ADDR_W-1:0];
            state_nxt = ldsa_pkg::ST_PONG;
          end else begin
            addr_nxt  = low_r[ldsa_pkg::ADDR_W-1:0];
            low_nxt   = sum[MW-1:0];
            state_nxt = ldsa_pkg::ST_PONG;
          end
        end
      end

      ldsa_pkg::ST_PONG: begin
        // Pong copy sits right above the primary; the entry is written here.
        ctl.wr_en = 1'b1;
        if ((role_r == ldsa_pkg::ROLE_IN) && tile_r && fits) begin
          pong_nxt    = 1'b1;
          paddr_nxt   = low_r[ldsa_pkg::ADDR_W-1:0];
          low_nxt     = sum[MW-1:0];
          wr_data.rel = {size[SW-2:0], 1'b0};
        end
        state_nxt = ldsa_pkg::ST_EMIT;
      end

      ldsa_pkg::ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          o_status_nxt  = status_r;
          o_addr_nxt    = addr_r;
          o_pong_nxt    = pong_r;
          o_paddr_nxt   = paddr_r;
          o_free_nxt    = diff[MW] ? '0 : diff[MW-1:0];
          state_nxt     = ldsa_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = ldsa_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ldsa_pkg::ST_IDLE;
      sram_r      <= ldsa_pkg::SCRATCH_BYTES_RST;
      low_r       <= '0;
      high_r      <= ldsa_pkg::SCRATCH_BYTES_RST;
      cnt_r       <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      low_r       <= low_nxt;
      high_r      <= high_nxt;
      cnt_r       <= cnt_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        sram_r <= cfg_data;
      end
    end
  end

  // Request and result payload.
  always_ff @(posedge clk) begin
    slot_r     <= slot_nxt;
    role_r     <= role_nxt;
    tile_r     <= tile_nxt;
    first_r    <= first_nxt;
    last_r     <= last_nxt;
    status_r   <= status_nxt;
    addr_r     <= addr_nxt;
    pong_r     <= pong_nxt;
    paddr_r    <= paddr_nxt;
    o_status_r <= o_status_nxt;
    o_addr_r   <= o_addr_nxt;
    o_pong_r   <= o_pong_nxt;
    o_paddr_r  <= o_paddr_nxt;
    o_free_r   <= o_free_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = o_status_r;
  assign out_tdata  = {6'd0, o_free_r, o_paddr_r, o_pong_r, o_addr_r};

endmodule

// ----- rtl/core/ldsa_checker.sv -----
// ----------------------------------------------------------------------------
// ldsa_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module ldsa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [79:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // A stalled result word holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // A spilled request reports no addresses and no pong copy.
  a_spill_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ldsa_pkg::STAT_OK) |->
      (out_tdata[48:0] == 49'd0))
    else $error("spilled request reports an address");

  // Status is never the unused code.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser != ldsa_pkg::STAT_BAD))
    else $error("unused status code on result");

  // One request is in work at a time: no accept in the cycle after an accept.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while another is in work");

endmodule

bind liveness_dual_end_sram_allocator_core ldsa_checker u_ldsa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the double-ended scratch allocator against a cycle-free predictor.
// Directed requests cover zero and oversize buffers, ping/pong placement,
// output placement from the top, retirement, clears and the scratch size
// extremes. Kernels of random requests follow: mostly in first-use order,
// some noise. Both stream sides idle at random, and the sink is held off once
// so that the block backs up. Every result word is compared field by field.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned TABLE_DEPTH  = 64;
  localparam int unsigned ALIGN        = 64;
  localparam int unsigned QUIET_LIMIT  = 10000;
  localparam int unsigned HOLD_CYCLES  = 1500;
  localparam int unsigned TAIL_CYCLES  = 100;
  localparam int unsigned REPORT_LIMIT = 10;

  // Roles without a name in the package.
  localparam logic [ldsa_pkg::ROLE_W-1:0] ROLE_MID  = 2'd2;
  localparam logic [ldsa_pkg::ROLE_W-1:0] ROLE_ODD  = 2'd3;

  typedef struct packed {
    logic                        mode;
    logic [ldsa_pkg::ROLE_W-1:0] role;
    logic [24:0]                 bytes;
    logic [ldsa_pkg::STEP_W-1:0] first_use;
    logic [ldsa_pkg::STEP_W-1:0] last_use;
    logic                        tile;
  } alloc_req_t;

  typedef struct packed {
    logic [ldsa_pkg::STAT_W-1:0] status;
    logic [ldsa_pkg::ADDR_W-1:0] address;
    logic                        pong_placed;
    logic [ldsa_pkg::ADDR_W-1:0] pong_address;
    logic [ldsa_pkg::MARK_W-1:0] free_bytes;
  } alloc_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [24:0] cfg_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;
  logic [1:0]  out_tuser;

  // Idle rates in percent and the long sink hold-off.
  int unsigned send_idle_pct = 22;
  int unsigned recv_idle_pct = 55;
  logic        sink_hold = 1'b0;

  // Predictor state.
  logic [24:0]                 sram_bytes;
  logic [63:0]                 lo_mark;
  logic [63:0]                 hi_mark;
  logic                        slot_live [TABLE_DEPTH];
  logic [ldsa_pkg::STEP_W-1:0] slot_last [TABLE_DEPTH];
  logic [ldsa_pkg::REL_W-1:0]  slot_release [TABLE_DEPTH];

  alloc_res_t  expected_placements[$];
  int unsigned mismatch_count = 0;
  int unsigned stray_results = 0;
  int unsigned quiet_cycles = 0;

  liveness_dual_end_sram_allocator_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Bytes between the marks, zero once they have crossed.
  function automatic logic [63:0] space_left();
    return (hi_mark >= lo_mark) ? hi_mark - lo_mark : 64'd0;
  endfunction

  // Empties the table and restores both marks for a new kernel.
  function automatic void restart_tracker();
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      slot_live[i] = 1'b0;
    end
    lo_mark = 64'd0;
    hi_mark = {39'd0, sram_bytes};
  endfunction

  function automatic alloc_res_t predict_placement(alloc_req_t r);
    alloc_res_t res;
    logic [63:0] size;
    logic [63:0] rel;
    logic [63:0] addr;
    logic [63:0] pong_addr;
    logic [63:0] left;
    int slot;
    res = '0;
    addr = 64'd0;
    pong_addr = 64'd0;
    slot = -1;
    if (r.mode == ldsa_pkg::MODE_CLEAR) begin
      restart_tracker();
    end else begin
      // Retire every buffer that is dead by this request's first use.
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (slot_live[i] && slot_last[i] < r.first_use) begin
          slot_live[i] = 1'b0;
          lo_mark = (lo_mark > {38'd0, slot_release[i]}) ?
                    lo_mark - {38'd0, slot_release[i]} : 64'd0;
        end
      end
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (!slot_live[i] && slot < 0) begin
          slot = i;
        end
      end
      size = (({39'd0, r.bytes} + ALIGN - 1) / ALIGN) * ALIGN;
      if (slot < 0) begin
        res.status = ldsa_pkg::STAT_FULL;
      end else if (size > space_left()) begin
        res.status = ldsa_pkg::STAT_NOROOM;
      end else begin
        res.status = ldsa_pkg::STAT_OK;
        if (r.role == ldsa_pkg::ROLE_OUT) begin
          hi_mark = hi_mark - size;
          addr = hi_mark;
          rel = 64'd0;
        end else begin
          addr = lo_mark;
          lo_mark = lo_mark + size;
          rel = size;
          // An input inside a tile loop gets a pong copy if it still fits.
          if (r.role == ldsa_pkg::ROLE_IN && r.tile && size <= space_left()) begin
            pong_addr = lo_mark;
            lo_mark = lo_mark + size;
            res.pong_placed = 1'b1;
            rel = size * 2;
          end
        end
        slot_live[slot] = 1'b1;
        slot_last[slot] = r.last_use;
        slot_release[slot] = rel[ldsa_pkg::REL_W-1:0];
      end
    end
    left = space_left();
    res.address = addr[ldsa_pkg::ADDR_W-1:0];
    res.pong_address = pong_addr[ldsa_pkg::ADDR_W-1:0];
    res.free_bytes = left[ldsa_pkg::MARK_W-1:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  function automatic alloc_req_t make_req(logic mode, logic [ldsa_pkg::ROLE_W-1:0] role,
                                          logic [24:0] bytes,
                                          logic [ldsa_pkg::STEP_W-1:0] first_use,
                                          logic [ldsa_pkg::STEP_W-1:0] last_use,
                                          logic tile);
    alloc_req_t r;
    r.mode = mode;
    r.role = role;
    r.bytes = bytes;
    r.first_use = first_use;
    r.last_use = last_use;
    r.tile = tile;
    return r;
  endfunction

  // Offers one request word, with random idle cycles ahead of it, and records
  // its expected result once the block takes it.
  task automatic send_request(input alloc_req_t r);
    alloc_res_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {6'd0, r.tile, r.last_use, r.first_use, r.bytes};
    in_tuser <= {r.role, r.mode};
    do @(posedge clk); while (!in_tready);
    res = predict_placement(r);
    expected_placements.insert(expected_placements.size(), res);
  endtask

  // Drops the request stream and waits for every outstanding result.
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_placements.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Writes the scratch size while the block is idle.
  task automatic write_scratch_size(input logic [24:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    sram_bytes = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random kernels: a clear most of the time, then requests in first-use
  // order with a lifetime and size profile per kernel, plus some noise.
  task automatic run_kernels(input int unsigned n_items);
    alloc_req_t r;
    int unsigned sent;
    int unsigned len;
    int unsigned span_kind;
    int unsigned size_kind;
    logic [ldsa_pkg::STEP_W-1:0] cur_step;
    sent = 0;
    while (sent < n_items) begin
      len = $urandom_range(100, 1);
      span_kind = $urandom_range(2);
      size_kind = $urandom_range(2);
      cur_step = ldsa_pkg::STEP_W'($urandom);
      if ($urandom_range(3) != 0) begin
        send_request(make_req(ldsa_pkg::MODE_CLEAR, ldsa_pkg::ROLE_W'($urandom),
                              25'($urandom), ldsa_pkg::STEP_W'($urandom),
                              ldsa_pkg::STEP_W'($urandom), 1'($urandom)));
        sent++;
      end
      for (int k = 0; k < len && sent < n_items; k++) begin
        if ($urandom_range(9) == 0) begin
          r = make_req($urandom_range(7) == 0, ldsa_pkg::ROLE_W'($urandom), 25'($urandom),
                       ldsa_pkg::STEP_W'($urandom), ldsa_pkg::STEP_W'($urandom),
                       1'($urandom));
        end else begin
          cur_step = cur_step + ldsa_pkg::STEP_W'($urandom_range(3));
          r = make_req(ldsa_pkg::MODE_PLACE, ldsa_pkg::ROLE_W'($urandom), '0, cur_step, '0,
                       1'($urandom));
          case (span_kind)
            0: r.last_use = cur_step + ldsa_pkg::STEP_W'($urandom_range(24));
            1: r.last_use = '1;
            default: r.last_use = ldsa_pkg::STEP_W'($urandom);
          endcase
          case (size_kind)
            0: r.bytes = 25'($urandom_range(512));
            1: r.bytes = 25'($urandom_range(65536));
            default: r.bytes = ($urandom_range(15) == 0) ? 25'($urandom) :
                               25'($urandom_range(262144));
          endcase
        end
        send_request(r);
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Placement rules at the reset size: ping/pong, outputs from the top, role
  // three, a request too big for anything, a pong that does not fit, then
  // retirement of dead buffers and a clear.
  task automatic test_basic_placement();
    send_request(make_req(ldsa_pkg::MODE_PLACE, ldsa_pkg::ROLE_IN,  25'd0,
                          16'd0, 16'd10, 1'b1));
    send_request(make_req(ldsa_pkg::MODE_PLACE, ldsa_pkg::ROLE_IN,  25'd100,
                          16'd1, 16'd5, 1'b1));
    send_request(make_req(ldsa_pkg::MODE_PLACE, ldsa_pkg::ROLE_OUT, 25'd1,
                          16'd2, 16'd3, 1'b1));
    send_request(make_req(ldsa_pkg::MODE_PLACE, ROLE_ODD, 25'd65,
                          16'd3, 16'hFFFF, 1'b0));
    send_request(make_req(ldsa_pkg::MODE_PLACE, ROLE_MID, 25'h1FFFFFF,
                          16'd3, 16'd4, 1'b1));
    send_request(make_req(ldsa_pkg::MODE_PLACE, ldsa_pkg::ROLE_IN,  25'd600000,
                          16'd4, 16'd6, 1'b1));
    send_request(make_req(ldsa_pkg::MODE_PLACE, ROLE_MID, 25'd64,
                          16'd7, 16'd7, 1'b0));
    send_request(make_req(ldsa_pkg::MODE_PLACE, ldsa_pkg::ROLE_OUT, 25'd4096,
                          16'hFFFF, 16'hFFFF, 1'b0));
    send_request(make_req(ldsa_pkg::MODE_CLEAR, ldsa_pkg::ROLE_IN,  25'd0,
                          16'd0, 16'd0, 1'b0));
    drain();
  endtask

  // Smallest and largest scratch sizes, including a mark that sits exactly at
  // the 24-bit address limit.
  task automatic test_size_extremes();
    write_scratch_size(25'd0);
    send_request(make_req(ldsa_pkg::MODE_CLEAR, ROLE_MID, 25'd0, 16'd0, 16'd0, 1'b0));
    send_request(make_req(ldsa_pkg::MODE_PLACE, ROLE_MID, 25'd0, 16'd0, 16'd9, 1'b0));
    send_request(make_req(ldsa_pkg::MODE_PLACE, ldsa_pkg::ROLE_IN, 25'd1,
                          16'd0, 16'd9, 1'b1));
    send_request(make_req(ldsa_pkg::MODE_PLACE, ldsa_pkg::ROLE_OUT, 25'd0,
                          16'd1, 16'd9, 1'b0));
    send_request(make_req(ldsa_pkg::MODE_PLACE, ldsa_pkg::ROLE_IN, 25'd0,
                          16'd1, 16'd9, 1'b1));
    drain();
    write_scratch_size(25'd16777216);
    send_request(make_req(ldsa_pkg::MODE_CLEAR, ldsa_pkg::ROLE_IN, 25'd0,
                          16'd0, 16'd0, 1'b0));
    send_request(make_req(ldsa_pkg::MODE_PLACE, ldsa_pkg::ROLE_IN, 25'd16777216,
                          16'd0, 16'd5, 1'b1));
    send_request(make_req(ldsa_pkg::MODE_PLACE, ROLE_MID, 25'd0,
                          16'd1, 16'd5, 1'b0));
    send_request(make_req(ldsa_pkg::MODE_PLACE, ldsa_pkg::ROLE_OUT, 25'd64,
                          16'd2, 16'd5, 1'b0));
    send_request(make_req(ldsa_pkg::MODE_PLACE, ROLE_MID, 25'd0,
                          16'd100, 16'd100, 1'b0));
    send_request(make_req(ldsa_pkg::MODE_PLACE, ldsa_pkg::ROLE_OUT, 25'd16777153,
                          16'd101, 16'd200, 1'b0));
    drain();
  endtask

  // Random kernels under one idle profile and one scratch size.
  task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct,
                                     input logic [24:0] size, input int unsigned n_items);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    write_scratch_size(size);
    run_kernels(n_items);
    drain();
  endtask

  // The sink stops for a long stretch while requests keep coming.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    fork
      begin
        sink_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        sink_hold = 1'b0;
      end
    join_none
    run_kernels(40);
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // Sink, checker and watchdog
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    out_tready <= !sink_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    alloc_res_t got;
    alloc_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.status = out_tuser;
      got.address = out_tdata[23:0];
      got.pong_placed = out_tdata[24];
      got.pong_address = out_tdata[48:25];
      got.free_bytes = out_tdata[73:49];
      if (expected_placements.size() == 0) begin
        stray_results++;
        $display("result word with nothing expected: status %0d address %h", got.status,
                 got.address);
      end else begin
        want = expected_placements.pop_front();
        if (got.status != want.status || got.address != want.address ||
            got.pong_placed != want.pong_placed || got.pong_address != want.pong_address ||
            got.free_bytes != want.free_bytes) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("result word differs (expected / actual): status %0d / %0d",
                     want.status, got.status);
            $display("  address %h / %h, pong %0d / %0d, pong_address %h / %h",
                     want.address, got.address, want.pong_placed, got.pong_placed,
                     want.pong_address, got.pong_address);
            $display("  free_bytes %0d / %0d", want.free_bytes, got.free_bytes);
          end
        end
      end
    end
  end

  // Ends the run if nothing moves on any channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("liveness_dual_end_sram_allocator_core: mismatch");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    sram_bytes = ldsa_pkg::SCRATCH_BYTES_RST;
    restart_tracker();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_basic_placement();
    test_size_extremes();
    test_random_traffic(22, 55, 25'($urandom_range(16777216)), 450);
    test_random_traffic(55, 22, 25'd4096, 450);
    test_backpressure();
    test_random_traffic(0, 0, ldsa_pkg::SCRATCH_BYTES_RST, 450);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && stray_results == 0 && expected_placements.size() == 0) begin
      $display("liveness_dual_end_sram_allocator_core: match");
    end else begin
      $display("liveness_dual_end_sram_allocator_core: mismatch");
    end
    $finish;
  end

endmodule

// ----- liveness_dual_end_sram_allocator_core.f -----
rtl/core/ldsa_pkg.sv
rtl/core/ldsa_cell.sv
rtl/core/ldsa_align.sv
rtl/core/liveness_dual_end_sram_allocator_core.sv
rtl/core/ldsa_checker.sv
test/tb_top.sv
